// File: hw/rtl/ckx_pkg.sv
package ckx_pkg;

    // Fixed field widths
    localparam int CHAR_W = 8;
    localparam int KLEN_W = 5;
    localparam int CODE_W = 62;
    localparam int RUN_W  = 6;
    localparam int BASE_W = 2;
    localparam int READ_W = 32;

    // Configuration reset values and limits
    localparam logic [KLEN_W-1:0] K_MIN   = 5'd3;
    localparam logic [KLEN_W-1:0] K_RESET = 5'd21;
    localparam logic [RUN_W-1:0]  RUN_MAX = 6'd63;

    // Complement of a 2-bit base code: A<->T, C<->G
    localparam logic [BASE_W-1:0] BASE_COMP = 2'b10;

    // Nucleotide characters
    localparam logic [CHAR_W-1:0] CH_A_UP = 8'h41;
    localparam logic [CHAR_W-1:0] CH_A_LO = 8'h61;
    localparam logic [CHAR_W-1:0] CH_C_UP = 8'h43;
    localparam logic [CHAR_W-1:0] CH_C_LO = 8'h63;
    localparam logic [CHAR_W-1:0] CH_G_UP = 8'h47;
    localparam logic [CHAR_W-1:0] CH_G_LO = 8'h67;
    localparam logic [CHAR_W-1:0] CH_T_UP = 8'h54;
    localparam logic [CHAR_W-1:0] CH_T_LO = 8'h74;
    localparam logic [CHAR_W-1:0] CH_N_UP = 8'h4E;
    localparam logic [CHAR_W-1:0] CH_N_LO = 8'h6E;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_KMER_LENGTH = 2'd0,
        CFG_PREFIX_CODE = 2'd1,
        CFG_PREFIX_MASK = 2'd2
    } cfg_idx_t;

    // Step command broadcast to every cell of the row
    typedef struct packed {
        logic              shift;
        logic              clear;
        logic              known;
        logic [BASE_W-1:0] base;
    } step_t;

endpackage

// File: hw/rtl/ckx_cell.sv
module ckx_cell #(
    parameter bit LEAD = 1'b0
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ckx_pkg::step_t            step,
    input  logic                      in_win,
    input  logic                      is_top,
    input  logic [ckx_pkg::BASE_W-1:0] fwd_in,
    input  logic [ckx_pkg::BASE_W-1:0] rev_in,
    output logic [ckx_pkg::BASE_W-1:0] fwd_out,
    output logic [ckx_pkg::BASE_W-1:0] rev_out
);

    logic [ckx_pkg::BASE_W-1:0] fwd_reg;
    logic [ckx_pkg::BASE_W-1:0] fwd_next;
    logic [ckx_pkg::BASE_W-1:0] rev_reg;
    logic [ckx_pkg::BASE_W-1:0] rev_next;
    logic [ckx_pkg::BASE_W-1:0] fwd_nb;
    logic [ckx_pkg::BASE_W-1:0] rev_nb;
    logic [ckx_pkg::BASE_W-1:0] comp;

    // Pick up neighbour values; the lead cell takes the new base on the forward strand instead
    always_comb begin
        if (LEAD) begin
            fwd_nb = step.known ? step.base : '0;
        end else begin
            fwd_nb = step.clear ? '0 : fwd_in;
        end
        rev_nb = step.clear ? '0 : rev_in;
        comp   = (step.known && is_top) ? (step.base ^ ckx_pkg::BASE_COMP) : '0;
        fwd_next = in_win ? fwd_nb : '0;
        rev_next = in_win ? (rev_nb | comp) : '0;
    end

    // Advance one base position per step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= '0;
            rev_reg <= '0;
        end else if (step.shift) begin
            fwd_reg <= fwd_next;
            rev_reg <= rev_next;
        end
    end

    assign fwd_out = fwd_reg;
    assign rev_out = rev_reg;

endmodule

// File: hw/rtl/ckx_row.sv
module ckx_row #(
    parameter int MAX_K = 31
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ckx_pkg::step_t              step,
    input  logic [ckx_pkg::KLEN_W-1:0]  k_eff,
    output logic [2*MAX_K-1:0]          fwd_code,
    output logic [2*MAX_K-1:0]          rev_code
);

    logic [ckx_pkg::BASE_W-1:0] fwd_q [MAX_K];
    logic [ckx_pkg::BASE_W-1:0] rev_q [MAX_K];
    logic [ckx_pkg::BASE_W-1:0] fwd_in [MAX_K];
    logic [ckx_pkg::BASE_W-1:0] rev_in [MAX_K];
    logic [MAX_K-1:0]           in_win;
    logic [MAX_K-1:0]           is_top;

    // Forward strand moves up the row, reverse strand moves down
    for (genvar i = 0; i < MAX_K; i++) begin : g_cell
        assign in_win[i] = ckx_pkg::KLEN_W'(i) < k_eff;
        assign is_top[i] = ckx_pkg::KLEN_W'(i + 1) == k_eff;

        if (i == 0) begin : g_first
            assign fwd_in[i] = '0;
        end else begin : g_inner
            assign fwd_in[i] = fwd_q[i-1];
        end

        if (i == MAX_K - 1) begin : g_last
            assign rev_in[i] = '0;
        end else begin : g_lower
            assign rev_in[i] = rev_q[i+1];
        end

        ckx_cell #(
            .LEAD (i == 0)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .step    (step),
            .in_win  (in_win[i]),
            .is_top  (is_top[i]),
            .fwd_in  (fwd_in[i]),
            .rev_in  (rev_in[i]),
            .fwd_out (fwd_q[i]),
            .rev_out (rev_q[i])
        );

        assign fwd_code[2*i +: 2] = fwd_q[i];
        assign rev_code[2*i +: 2] = rev_q[i];
    end

endmodule

// File: hw/rtl/canonical_kmer_extractor.sv
// Canonical k-mer extractor.
// Input channel s_*: one ASCII base per item in s_tdata[7:0]; s_tuser[0] marks
// the first base of a read. Every accepted base gives exactly one result item
// on m_*: m_tdata holds the canonical 2-bit code and the read number,
// m_tuser holds the valid flag and the strand flag.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr (0 k-mer length,
// 1 prefix code, 2 prefix mask) at the clock edge; write only while idle.
// Throughput: one item per cycle unless the result channel stalls. The forward and
// reverse codes sit in a row of MAX_K cells, one base each, that all shift on the
// accepting edge. Pipeline: the cells update on the accepting edge, then the strand
// compare and prefix match are registered into the output register, and m_tvalid
// rises, as the row drains.
// Stall: while m_tready is low the result holds; one further item is taken
// into the row, then s_tready drops until the output register drains.
// Reset (aresetn low, synchronous): codes and clean-run count clear, the read
// counter goes to all ones so the first read start numbers read 0, k returns
// to 21, prefix code and mask to 0, and both channels empty.
module canonical_kmer_extractor #(
    parameter int MAX_K           = 31,
    parameter int READ_COUNT_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] base_char
    input  logic [0:0]  s_tuser,    // [0] read_start
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,    // [61:0] canonical_code, [93:62] read_number, [95:94] zero
    output logic [1:0]  m_tuser,    // [0] kmer_valid, [1] from_reverse
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [61:0] cfg_wdata
);

    localparam int CW = ckx_pkg::CODE_W;

    logic [ckx_pkg::KLEN_W-1:0] klen_reg;
    logic [CW-1:0]              pcode_reg;
    logic [CW-1:0]              pmask_reg;
    logic [ckx_pkg::KLEN_W-1:0] k_eff;

    logic                       s_acc;
    logic                       adv;
    logic                       p1_valid_reg;
    logic                       p1_valid_next;
    logic [ckx_pkg::RUN_W-1:0]  run_reg;
    logic [ckx_pkg::RUN_W-1:0]  run_next;
    logic [ckx_pkg::RUN_W-1:0]  run_base;
    logic [READ_COUNT_BITS-1:0] cnt_reg;
    logic [READ_COUNT_BITS-1:0] cnt_next;
    logic                       known;
    logic                       is_n;
    ckx_pkg::step_t             step;

    logic [2*MAX_K-1:0]         fwd_vec;
    logic [2*MAX_K-1:0]         rev_vec;
    logic [CW-1:0]              fwd;
    logic [CW-1:0]              rev;
    logic                       rev_lt;
    logic                       same;
    logic                       fwd_hit;
    logic                       rev_hit;
    logic                       run_ok;

    logic                       m_valid_reg;
    logic                       m_valid_next;
    logic [CW-1:0]              canon_reg;
    logic                       from_rev_reg;
    logic                       kvalid_reg;
    logic [ckx_pkg::READ_W-1:0] rnum_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            klen_reg  <= ckx_pkg::K_RESET;
            pcode_reg <= '0;
            pmask_reg <= '0;
        end else if (cfg_we) begin
            unique case (ckx_pkg::cfg_idx_t'(cfg_addr))
                ckx_pkg::CFG_KMER_LENGTH: klen_reg  <= cfg_wdata[ckx_pkg::KLEN_W-1:0];
                ckx_pkg::CFG_PREFIX_CODE: pcode_reg <= cfg_wdata;
                ckx_pkg::CFG_PREFIX_MASK: pmask_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp k to the supported range
    always_comb begin
        if (klen_reg < ckx_pkg::K_MIN) begin
            k_eff = ckx_pkg::K_MIN;
        end else if (klen_reg > ckx_pkg::KLEN_W'(MAX_K)) begin
            k_eff = ckx_pkg::KLEN_W'(MAX_K);
        end else begin
            k_eff = klen_reg;
        end
    end

    // Handshake: the row is stage one, the output register stage two
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = !p1_valid_reg || adv;
    assign s_acc    = s_tvalid && s_tready;

    // Decode the character
    always_comb begin
        case (s_tdata) inside
            ckx_pkg::CH_A_UP, ckx_pkg::CH_A_LO, ckx_pkg::CH_C_UP, ckx_pkg::CH_C_LO,
            ckx_pkg::CH_G_UP, ckx_pkg::CH_G_LO, ckx_pkg::CH_T_UP, ckx_pkg::CH_T_LO:
                known = 1'b1;
            default:
                known = 1'b0;
        endcase
        is_n = (s_tdata == ckx_pkg::CH_N_UP) || (s_tdata == ckx_pkg::CH_N_LO);
    end

    assign step.shift = s_acc;
    assign step.clear = s_tuser[0];
    assign step.known = known;
    assign step.base  = s_tdata[2:1];

    // Clean-run count and read counter
    always_comb begin
        run_base = s_tuser[0] ? '0 : run_reg;
        if (is_n) begin
            run_next = '0;
        end else if (run_base < ckx_pkg::RUN_MAX) begin
            run_next = run_base + 1'b1;
        end else begin
            run_next = run_base;
        end
        cnt_next = s_tuser[0] ? cnt_reg + 1'b1 : cnt_reg;
        if (s_acc) begin
            p1_valid_next = 1'b1;
        end else if (adv) begin
            p1_valid_next = 1'b0;
        end else begin
            p1_valid_next = p1_valid_reg;
        end
        m_valid_next = adv ? p1_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            run_reg      <= '0;
            cnt_reg      <= '1;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (s_acc) begin
                run_reg <= run_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    // Row of base cells
    ckx_row #(
        .MAX_K (MAX_K)
    ) u_row (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .k_eff    (k_eff),
        .fwd_code (fwd_vec),
        .rev_code (rev_vec)
    );

    // Strand compare and prefix match, both strands in parallel
    assign fwd     = CW'(fwd_vec);
    assign rev     = CW'(rev_vec);
    assign rev_lt  = rev < fwd;
    assign same    = fwd == rev;
    assign fwd_hit = (fwd & pmask_reg) == pcode_reg;
    assign rev_hit = (rev & pmask_reg) == pcode_reg;
    assign run_ok  = run_reg >= ckx_pkg::RUN_W'(k_eff);

    // Load the output register as stage one drains
    always_ff @(posedge aclk) begin
        if (adv && p1_valid_reg) begin
            canon_reg    <= rev_lt ? rev : fwd;
            from_rev_reg <= rev_lt;
            kvalid_reg   <= run_ok && !same && (rev_lt ? rev_hit : fwd_hit);
            rnum_reg     <= ckx_pkg::READ_W'(cnt_reg);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, rnum_reg, canon_reg};
    assign m_tuser  = {from_rev_reg, kvalid_reg};

endmodule

// File: hw/rtl/ckx_checker.sv
module ckx_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // Reset empties the result channel
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // An empty output stage never blocks input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // A stalled result holds
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped under stall");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");

endmodule

bind canonical_kmer_extractor ckx_checker u_ckx_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_ITEMS  = 130;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 80;
    localparam int SETTLE_TICKS = 4;

    // One expected result item
    typedef struct packed {
        logic                       kmer_ok;
        logic [ckx_pkg::CODE_W-1:0] code;
        logic                       from_rc;
        logic [ckx_pkg::READ_W-1:0] read_no;
    } kmer_res_t;

    // One directed stimulus row; want is used only where typed is set
    typedef struct packed {
        logic [ckx_pkg::CHAR_W-1:0] ch;
        logic                       st;
        logic                       typed;
        kmer_res_t                  want;
    } dir_row_t;

    localparam logic [ckx_pkg::CHAR_W-1:0] LETTERS [8] = '{
        ckx_pkg::CH_A_UP, ckx_pkg::CH_A_LO, ckx_pkg::CH_C_UP, ckx_pkg::CH_C_LO,
        ckx_pkg::CH_G_UP, ckx_pkg::CH_G_LO, ckx_pkg::CH_T_UP, ckx_pkg::CH_T_LO
    };

    // Directed part, run with k = 3 and an open prefix filter
    localparam dir_row_t DIRECTED [21] = '{
        '{ckx_pkg::CH_A_UP, 1'b0, 1'b1, '{1'b0, 62'd0, 1'b0, 32'hFFFF_FFFF}},
        '{ckx_pkg::CH_N_LO, 1'b1, 1'b1, '{1'b0, 62'd0, 1'b0, 32'd0}},
        '{ckx_pkg::CH_C_UP, 1'b0, 1'b1, '{1'b0, 62'd1, 1'b0, 32'd0}},
        '{ckx_pkg::CH_G_LO, 1'b0, 1'b0, '0},
        '{ckx_pkg::CH_T_LO, 1'b0, 1'b1, '{1'b1, 62'd7, 1'b1, 32'd0}},
        '{ckx_pkg::CH_A_LO, 1'b0, 1'b0, '0},
        '{ckx_pkg::CH_C_LO, 1'b0, 1'b0, '0},
        '{ckx_pkg::CH_G_UP, 1'b0, 1'b0, '0},
        '{ckx_pkg::CH_T_UP, 1'b0, 1'b0, '0},
        '{ckx_pkg::CH_N_UP, 1'b0, 1'b0, '0},
        '{8'h00,            1'b1, 1'b1, '{1'b0, 62'd0, 1'b0, 32'd1}},
        '{8'hFF,            1'b0, 1'b1, '{1'b0, 62'd0, 1'b0, 32'd1}},
        '{8'h2A,            1'b0, 1'b1, '{1'b0, 62'd0, 1'b0, 32'd1}},
        '{ckx_pkg::CH_T_UP, 1'b0, 1'b0, '0},
        '{ckx_pkg::CH_T_UP, 1'b0, 1'b0, '0},
        '{ckx_pkg::CH_A_UP, 1'b1, 1'b0, '0},
        '{ckx_pkg::CH_A_UP, 1'b0, 1'b0, '0},
        '{ckx_pkg::CH_A_UP, 1'b0, 1'b1, '{1'b1, 62'd0, 1'b0, 32'd2}},
        '{8'hAA,            1'b0, 1'b0, '0},
        '{8'h55,            1'b0, 1'b0, '0},
        '{8'h78,            1'b0, 1'b0, '0}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [61:0] cfg_wdata;

    // Predictor state and its copy of the registers
    logic [ckx_pkg::CODE_W-1:0] fwd_code;
    logic [ckx_pkg::CODE_W-1:0] rc_code;
    logic [ckx_pkg::RUN_W-1:0]  clean_len;
    logic [ckx_pkg::READ_W-1:0] read_ctr;
    logic [ckx_pkg::KLEN_W-1:0] k_len;
    logic [ckx_pkg::CODE_W-1:0] p_code;
    logic [ckx_pkg::CODE_W-1:0] p_mask;

    kmer_res_t kmers_due [$];
    int        failures = 0;
    int        cycle_cnt = 0;
    int        rx_taken;
    int        tx_calm;

    canonical_kmer_extractor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Roll one base into the predicted strands and return the result item
    function automatic kmer_res_t roll_base(logic [ckx_pkg::CHAR_W-1:0] ch, logic st);
        int unsigned keff;
        logic [63:0] kmask;
        logic [63:0] f64;
        logic [63:0] r64;
        logic [1:0]  b;
        logic        use_rc;
        kmer_res_t   r;
        keff = (k_len < ckx_pkg::K_MIN) ? ckx_pkg::K_MIN : k_len;
        if (keff > 31) keff = 31;
        kmask = (64'd1 << (2 * keff)) - 64'd1;
        if (st) begin
            fwd_code  = '0;
            rc_code   = '0;
            clean_len = '0;
            read_ctr  = read_ctr + 1'b1;
        end
        f64 = {2'b00, fwd_code} << 2;
        r64 = {2'b00, rc_code} >> 2;
        case (ch) inside
            ckx_pkg::CH_A_UP, ckx_pkg::CH_A_LO, ckx_pkg::CH_C_UP, ckx_pkg::CH_C_LO,
            ckx_pkg::CH_G_UP, ckx_pkg::CH_G_LO, ckx_pkg::CH_T_UP, ckx_pkg::CH_T_LO: begin
                b   = ch[2:1];
                f64 = f64 | {62'd0, b};
                r64 = r64 | ({62'd0, b ^ ckx_pkg::BASE_COMP} << (2 * (keff - 1)));
            end
            default: ;
        endcase
        fwd_code = ckx_pkg::CODE_W'(f64 & kmask);
        rc_code  = ckx_pkg::CODE_W'(r64 & kmask);
        if (ch == ckx_pkg::CH_N_UP || ch == ckx_pkg::CH_N_LO)
            clean_len = '0;
        else if (clean_len < ckx_pkg::RUN_MAX)
            clean_len = clean_len + 1'b1;
        use_rc    = rc_code < fwd_code;
        r.code    = use_rc ? rc_code : fwd_code;
        r.from_rc = use_rc;
        r.kmer_ok = (clean_len >= keff) && (fwd_code != rc_code)
                    && ((r.code & p_mask) == p_code);
        r.read_no = read_ctr;
        return r;
    endfunction

    // Offer one base after a random gap, hold until taken, then queue its result
    task automatic push_base(logic [ckx_pkg::CHAR_W-1:0] ch, logic st, logic typed,
                             kmer_res_t want);
        int gap;
        kmer_res_t got;
        if (tx_calm > 0) begin
            tx_calm--;
            gap = 0;
        end else if ($urandom_range(0, 19) == 0) begin
            tx_calm = $urandom_range(20, 50);
            gap = 0;
        end else begin
            gap = $urandom_range(0, 9);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= st;
        do @(posedge aclk); while (!s_tready);
        got = roll_base(ch, st);
        kmers_due.push_back(typed ? want : got);
    endtask

    // Write all three registers back to back while the block is idle
    task automatic load_config(logic [ckx_pkg::KLEN_W-1:0] kl,
                               logic [ckx_pkg::CODE_W-1:0] pc,
                               logic [ckx_pkg::CODE_W-1:0] pm);
        cfg_we    <= 1'b1;
        cfg_addr  <= ckx_pkg::CFG_KMER_LENGTH;
        cfg_wdata <= {{(ckx_pkg::CODE_W - ckx_pkg::KLEN_W){1'b0}}, kl};
        @(posedge aclk);
        cfg_addr  <= ckx_pkg::CFG_PREFIX_CODE;
        cfg_wdata <= pc;
        @(posedge aclk);
        cfg_addr  <= ckx_pkg::CFG_PREFIX_MASK;
        cfg_wdata <= pm;
        @(posedge aclk);
        cfg_we <= 1'b0;
        k_len  = kl;
        p_code = pc;
        p_mask = pm;
    endtask

    // Drop valid and wait until every queued result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (kmers_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    // Stimulus
    initial begin
        logic [ckx_pkg::KLEN_W-1:0] kl;
        logic [ckx_pkg::CODE_W-1:0] pc;
        logic [ckx_pkg::CODE_W-1:0] pm;
        logic [ckx_pkg::CHAR_W-1:0] ch;
        int sent;
        int len;
        int r;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = ckx_pkg::CFG_KMER_LENGTH;
        cfg_wdata = '0;
        aresetn   = 1'b0;
        tx_calm   = 0;
        fwd_code  = '0;
        rc_code   = '0;
        clean_len = '0;
        read_ctr  = '1;
        k_len     = ckx_pkg::K_RESET;
        p_code    = '0;
        p_mask    = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part
        load_config(5'd3, '0, '0);
        foreach (DIRECTED[i])
            push_base(DIRECTED[i].ch, DIRECTED[i].st, DIRECTED[i].typed, DIRECTED[i].want);
        drain_results();

        // Random reads under a sequence of register settings
        for (int ph = 0; ph < 7; ph++) begin
            pc = ckx_pkg::CODE_W'({$urandom, $urandom});
            case (ph)
                0: begin kl = 5'd0;  pm = '0; pc = '0; end
                1: begin kl = 5'd31; pm = '0; pc = '0; end
                2: begin kl = 5'd2;  pm = 62'h3; pc = pc & pm; end
                3: begin
                    kl = ckx_pkg::KLEN_W'($urandom_range(3, 31));
                    pm = ($urandom_range(0, 1) != 0) ? 62'h3 : 62'hF;
                    pc = pc & pm;
                end
                4: begin
                    kl = ckx_pkg::KLEN_W'($urandom_range(3, 31));
                    pm = '1;
                    pc = '1;
                end
                5: begin
                    kl = ckx_pkg::KLEN_W'($urandom_range(3, 31));
                    pm = 62'hF;
                    pc = (pc & pm) | (62'd1 << $urandom_range(4, 61));
                end
                default: begin kl = ckx_pkg::K_RESET; pm = '0; pc = '0; end
            endcase
            load_config(kl, pc, pm);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 90)
                                                  : $urandom_range(1, 40);
                // a few reads carry no start flag and run on from the last one
                for (int i = 0; i < len; i++) begin
                    r = $urandom_range(0, 99);
                    if (r < 84)
                        ch = LETTERS[$urandom_range(0, 7)];
                    else if (r < 92)
                        ch = ($urandom_range(0, 1) != 0) ? ckx_pkg::CH_N_UP
                                                         : ckx_pkg::CH_N_LO;
                    else
                        ch = ckx_pkg::CHAR_W'($urandom_range(0, 255));
                    push_base(ch, (i == 0) && ($urandom_range(0, 19) != 0), 1'b0, '0);
                    sent++;
                end
            end
            drain_results();
        end

        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Result side: random stalls, calm stretches and one long hold-off
    initial begin
        int  w;
        int  calm;
        bit  held;
        m_tready = 1'b0;
        calm     = 0;
        held     = 1'b0;
        rx_taken = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && rx_taken >= HOLD_AT) begin
                held = 1'b1;
                w = HOLD_CYCLES;
            end else if (calm > 0) begin
                calm--;
                w = 0;
            end else if ($urandom_range(0, 19) == 0) begin
                calm = $urandom_range(20, 50);
                w = 0;
            end else begin
                w = $urandom_range(0, 9);
            end
            if (w > 0) begin
                m_tready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            rx_taken++;
        end
    end

    // Compare each result item with the oldest expectation
    always @(posedge aclk) begin
        kmer_res_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (kmers_due.size() == 0) begin
                $error("result item with no expectation: code %h", m_tdata[61:0]);
                failures++;
            end else begin
                exp_res = kmers_due.pop_front();
                if (m_tuser[0] !== exp_res.kmer_ok) begin
                    $error("kmer_valid: expected %0d, got %0d", exp_res.kmer_ok, m_tuser[0]);
                    failures++;
                end
                if (m_tdata[61:0] !== exp_res.code) begin
                    $error("canonical_code: expected %h, got %h", exp_res.code,
                           m_tdata[61:0]);
                    failures++;
                end
                if (m_tuser[1] !== exp_res.from_rc) begin
                    $error("from_reverse: expected %0d, got %0d", exp_res.from_rc, m_tuser[1]);
                    failures++;
                end
                if (m_tdata[93:62] !== exp_res.read_no) begin
                    $error("read_number: expected %h, got %h", exp_res.read_no,
                           m_tdata[93:62]);
                    failures++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule

// File: canonical_kmer_extractor.f
hw/rtl/ckx_pkg.sv
hw/rtl/ckx_cell.sv
hw/rtl/ckx_row.sv
hw/rtl/canonical_kmer_extractor.sv
hw/rtl/ckx_checker.sv
dv/tb_top.sv
